/* rtl/cbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, widths and constants of the credit-based packet shaper.
// ----------------------------------------------------------------------------
package cbs_pkg;

   // system tick rate
   localparam int unsigned TICK_RATE_HZ  = 1000;
   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned MS_PER_S      = 1000;
   localparam int unsigned BYTE_MS       = BITS_PER_BYTE * MS_PER_S;

   // field widths
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned BPS_W      = 32;
   localparam int unsigned CRD_W      = 24;
   localparam int unsigned BYTES_W    = 16;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_IDX_W  = 1;

   // register reset values
   localparam logic [BPS_W-1:0] BPS_RESET = BPS_W'(1000000);
   localparam logic [CRD_W-1:0] CRD_RESET = CRD_W'(12000);

   // arithmetic widths
   localparam int unsigned DLY_NUM_W  = BYTES_W + $clog2(BYTE_MS);
   localparam int unsigned MS_W       = CRD_W + $clog2(MS_PER_S);
   localparam int unsigned TICKHZ_W   = $clog2(TICK_RATE_HZ + 1);
   localparam int unsigned DVD_W      = MS_W + TICKHZ_W;
   localparam int unsigned STEP_W     = $clog2(DVD_W + 1);
   localparam bit          TICK_IDENT = (TICK_RATE_HZ == MS_PER_S);

   // command queue
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_QUERY = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BANDWIDTH  = 1'b0,
      REG_MAX_CREDIT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      op_type                 op;
      logic [TICK_W-1:0]      now;
      logic [DLY_NUM_W-1:0]   dly_num;
   } cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DVD_W-1:0]     dividend;
      logic [BPS_W-1:0]     divisor;
      logic [STEP_W-1:0]    steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DVD_W-1:0]     quotient;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DLY_GO,
      ST_DLY_WAIT,
      ST_DTC_GO,
      ST_DTC_WAIT,
      ST_CRD_GO,
      ST_CRD_WAIT,
      ST_CTC_GO,
      ST_CTC_WAIT,
      ST_APPLY,
      ST_DONE
   } back_state_type;

endpackage

/* rtl/cbs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_if
// Request and response channels of the shaper, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbs_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [cbs_pkg::TICK_W-1:0]  now_tick;
   logic [cbs_pkg::BYTES_W-1:0] packet_bytes;

   modport source (output valid, output action, output now_tick, output packet_bytes,
                   input ready);
   modport sink   (input valid, input action, input now_tick, input packet_bytes,
                   output ready);
endinterface

interface cbs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ready_res;
   logic [cbs_pkg::TICK_W-1:0]  wakeup_tick;

   modport source (output valid, output ready_res, output wakeup_tick, input ready);
   modport sink   (input valid, input ready_res, input wakeup_tick, output ready);
endinterface

/* rtl/credit_based_packet_shaper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_based_packet_shaper
// Virtual-time credit shaper: decides whether the head packet may go and
// advances the activation time by the packet's transmission delay.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  req_port  in    valid/ready        action, now_tick, packet_bytes
//  rsp_port  out   valid/ready        ready_res, wakeup_tick
//  csr_*     in    csr_we, no stall   csr_index, csr_wdata
//
// A start item or a query that must wait goes from idle straight to the done
// state of the back part. A query that may go runs two divisions on the shared
// one-bit-a-cycle divider (29 steps for the delay, 34 for the credit), none
// if the bandwidth is zero. Reset is synchronous; activation time clears to
// zero, registers take their defaults. A two-entry queue lets requests be taken
// while the back part works and the response register waits on a stalled sink.
// ----------------------------------------------------------------------------
module credit_based_packet_shaper (
   input  logic                              clock,
   input  logic                              reset,
   cbs_req_if.sink                           req_port,
   cbs_rsp_if.source                         rsp_port,
   input  logic                              csr_we,
   input  logic [cbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cbs_pkg::*;

   logic    f_valid;
   logic    f_ready;
   cmd_type f_cmd;
   logic    b_valid;
   logic    b_ready;
   cmd_type b_cmd;

   // request intake
   cbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .cmd_valid (f_valid),
      .cmd_ready (f_ready),
      .cmd       (f_cmd)
   );

   // decoupling queue
   cbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_cmd    (b_cmd)
   );

   // execution
   cbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (b_valid),
      .cmd_ready (b_ready),
      .cmd       (b_cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_port)
   );

endmodule

/* rtl/cbs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_div
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned and the number of steps equals its significant width.
// ----------------------------------------------------------------------------
module cbs_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cbs_pkg::div_req_type req,
   output cbs_pkg::div_rsp_type rsp
);
   import cbs_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic [DVD_W-1:0]    dvd_ff;
   logic [DVD_W-1:0]    quo_ff;
   logic [BPS_W-1:0]    rem_ff;
   logic [BPS_W-1:0]    dsr_ff;

   logic [BPS_W:0]      rem_sh;
   logic [BPS_W:0]      rem_sub;
   logic                ge;
   logic [BPS_W-1:0]    rem_in;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = (rem_sh >= {1'b0, dsr_ff});
      rem_sub = rem_sh - {1'b0, dsr_ff};
      rem_in  = ge ? rem_sub[BPS_W-1:0] : rem_sh[BPS_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         dsr_ff <= req.divisor;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         quo_ff <= {quo_ff[DVD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* rtl/cbs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module cbs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cbs_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cbs_pkg::cmd_type pop_cmd
);
   import cbs_pkg::*;

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                push;
   logic                pop;

   assign push_ready = (cnt_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + QCNT_W'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* rtl/cbs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_front
// Accepts request transfers, classifies them and forms the delay numerator.
// ----------------------------------------------------------------------------
module cbs_front (
   input  logic             clock,
   input  logic             reset,
   cbs_req_if.sink          req,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cbs_pkg::cmd_type cmd
);
   import cbs_pkg::*;

   logic    cmd_valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    take;

   assign req.ready = !cmd_valid_ff || cmd_ready;
   assign take      = req.valid && req.ready;

   // classify and scale packet length to bit-milliseconds
   always_comb begin
      cmd_in.op      = req.action ? OP_START : OP_QUERY;
      cmd_in.now     = req.now_tick;
      cmd_in.dly_num = DLY_NUM_W'(DLY_NUM_W'(req.packet_bytes) * DLY_NUM_W'(BYTE_MS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (take) begin
         cmd_valid_ff <= 1'b1;
      end else if (cmd_ready) begin
         cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

/* rtl/cbs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_back
// Executes shaper commands: delay and credit divisions on the shared
// divider, activation time update and the response register.
// ----------------------------------------------------------------------------
module cbs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  cbs_pkg::cmd_type                  cmd,
   input  logic                              csr_we,
   input  logic [cbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cbs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   cbs_rsp_if.source                         rsp
);
   import cbs_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;

   logic [BPS_W-1:0]    bw_ff;
   logic [CRD_W-1:0]    crd_ff;
   logic [TICK_W-1:0]   next_act_ff;
   cmd_type             cur_ff;
   logic [MS_W-1:0]     ms_ff;
   logic [TICK_W-1:0]   dly_ff;
   logic [TICK_W-1:0]   mxd_ff;
   logic                res_rdy_ff;
   logic [TICK_W-1:0]   res_wake_ff;

   logic                rsp_valid_ff;
   logic                rsp_rdy_ff;
   logic [TICK_W-1:0]   rsp_wake_ff;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                bw_zero;
   logic                late;
   logic                out_free;
   logic                out_load;
   logic [TICK_W-1:0]   base;
   logic [TICK_W-1:0]   act_in;

   cbs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign bw_zero  = (bw_ff == '0);
   assign late     = (next_act_ff > cmd.now);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // credit clamp and new activation time
   always_comb begin
      base   = ((next_act_ff + mxd_ff) < cur_ff.now) ? (cur_ff.now - mxd_ff) : next_act_ff;
      act_in = base + dly_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_START || late) state_in = ST_DONE;
               else                            state_in = ST_DLY_GO;
            end
         end
         ST_DLY_GO: begin
            if (!bw_zero)        state_in = ST_DLY_WAIT;
            else if (TICK_IDENT) state_in = ST_CRD_GO;
            else                 state_in = ST_DTC_GO;
         end
         ST_DLY_WAIT: begin
            if (div_rsp.done) state_in = TICK_IDENT ? ST_CRD_GO : ST_DTC_GO;
         end
         ST_DTC_GO:   state_in = ST_DTC_WAIT;
         ST_DTC_WAIT: if (div_rsp.done) state_in = ST_CRD_GO;
         ST_CRD_GO: begin
            if (!bw_zero)        state_in = ST_CRD_WAIT;
            else if (TICK_IDENT) state_in = ST_APPLY;
            else                 state_in = ST_CTC_GO;
         end
         ST_CRD_WAIT: begin
            if (div_rsp.done) state_in = TICK_IDENT ? ST_APPLY : ST_CTC_GO;
         end
         ST_CTC_GO:   state_in = ST_CTC_WAIT;
         ST_CTC_WAIT: if (div_rsp.done) state_in = ST_APPLY;
         ST_APPLY:    state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs: command pop, divider launch, response load
   always_comb begin
      cmd_ready        = 1'b0;
      out_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = bw_ff;
      div_req.steps    = '0;
      unique case (state_ff) inside
         ST_IDLE: cmd_ready = 1'b1;
         ST_DLY_GO: begin
            div_req.start    = !bw_zero;
            div_req.dividend = {cur_ff.dly_num, {(DVD_W - DLY_NUM_W){1'b0}}};
            div_req.steps    = STEP_W'(DLY_NUM_W);
         end
         ST_CRD_GO: begin
            div_req.start    = !bw_zero;
            div_req.dividend = {MS_W'(MS_W'(crd_ff) * MS_W'(MS_PER_S)),
                                {(DVD_W - MS_W){1'b0}}};
            div_req.steps    = STEP_W'(MS_W);
         end
         ST_DTC_GO, ST_CTC_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(DVD_W'(ms_ff) * DVD_W'(TICK_RATE_HZ));
            div_req.divisor  = BPS_W'(MS_PER_S);
            div_req.steps    = STEP_W'(DVD_W);
         end
         ST_DONE: out_load = out_free;
         default: ;
      endcase
   end

   // state register and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bw_ff    <= BPS_RESET;
         crd_ff   <= CRD_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_BANDWIDTH:  bw_ff  <= csr_wdata[BPS_W-1:0];
               REG_MAX_CREDIT: crd_ff <= csr_wdata[CRD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // activation time
   always_ff @(posedge clock) begin
      if (reset) begin
         next_act_ff <= '0;
      end else if (state_ff == ST_IDLE && cmd_valid && cmd.op == OP_START) begin
         next_act_ff <= cmd.now;
      end else if (state_ff == ST_APPLY) begin
         next_act_ff <= act_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_ff      <= cmd;
               res_rdy_ff  <= 1'b0;
               res_wake_ff <= (cmd.op == OP_START) ? cmd.now : next_act_ff;
            end
         end
         ST_DLY_GO: begin
            if (bw_zero) begin
               ms_ff  <= MS_W'({TICK_W{1'b1}});
               dly_ff <= {TICK_W{1'b1}};
            end
         end
         ST_DLY_WAIT: begin
            if (div_rsp.done) begin
               ms_ff  <= div_rsp.quotient[MS_W-1:0];
               dly_ff <= div_rsp.quotient[TICK_W-1:0];
            end
         end
         ST_DTC_WAIT: if (div_rsp.done) dly_ff <= div_rsp.quotient[TICK_W-1:0];
         ST_CRD_GO: begin
            if (bw_zero) begin
               ms_ff  <= MS_W'({TICK_W{1'b1}});
               mxd_ff <= {TICK_W{1'b1}};
            end
         end
         ST_CRD_WAIT: begin
            if (div_rsp.done) begin
               ms_ff  <= div_rsp.quotient[MS_W-1:0];
               mxd_ff <= div_rsp.quotient[TICK_W-1:0];
            end
         end
         ST_CTC_WAIT: if (div_rsp.done) mxd_ff <= div_rsp.quotient[TICK_W-1:0];
         ST_APPLY: begin
            res_rdy_ff  <= 1'b1;
            res_wake_ff <= act_in;
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_rdy_ff  <= res_rdy_ff;
         rsp_wake_ff <= res_wake_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ready_res   = rsp_rdy_ff;
   assign rsp.wakeup_tick = rsp_wake_ff;

endmodule

/* test/credit_based_packet_shaper_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_based_packet_shaper_tb
// Self-checking bench for the credit shaper. A directed table covers the
// field extremes, start items, tick wrap, the credit clamp and a zero
// bandwidth. Random phases then follow, each with its register setting written first.
// Each response is checked against the table or an activation-time shadow,
// with random stalls on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module credit_based_packet_shaper_tb;
   import cbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_ITEMS = 205;
   localparam int unsigned MAX_REPORTS = 100;
   localparam int unsigned ROW_COUNT   = 28;

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      op_type                op;
      logic [TICK_W-1:0]     now;
      logic [BYTES_W-1:0]    bytes;
      logic                  typed;
      logic                  exp_ready;
      logic [TICK_W-1:0]     exp_wakeup;
      csr_reg_type           reg_sel;
      logic [CSR_DATA_W-1:0] reg_value;
   } stim_row_type;

   typedef struct packed {
      logic              ready_res;
      logic [TICK_W-1:0] wakeup_tick;
   } decision_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cbs_req_if req_if ();
   cbs_rsp_if rsp_if ();

   // shadow state of the shaper
   logic [TICK_W-1:0] shadow_activation;
   logic [BPS_W-1:0]  shadow_bandwidth;
   logic [CRD_W-1:0]  shadow_max_credit;

   decision_type pending_decisions [$];
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   bit           steady = 1'b0;
   bit           hold_request = 1'b0;
   int unsigned  hold_left = 0;

   // directed stimulus: kind, op, now, bytes, typed, ready, wakeup, register, value
   stim_row_type stim_rows [ROW_COUNT] = '{
      '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'h0000_0000,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 16'hFFFF, 1'b1, 1'b1, 32'd524,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'd100,       16'h0001, 1'b1, 1'b0, 32'd524,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'hFFFF_FFFF, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFF3,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 32'h0000_01FF,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 16'h0005, 1'b1, 1'b0, 32'h0000_01FF,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_START, 32'h1234_5678, 16'hFFFF, 1'b1, 1'b0, 32'h1234_5678,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h1234_5677, 16'hAAAA, 1'b1, 1'b0, 32'h1234_5678,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h1234_5678, 16'd1500, 1'b1, 1'b1, 32'h1234_5684,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_START, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_START, 32'hFFFF_FFFF, 16'h5555, 1'b1, 1'b0, 32'hFFFF_FFFF,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h0000_0005, 16'h0001, 1'b1, 1'b0, 32'hFFFF_FFFF,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_START, 32'd1000,      16'h0000, 1'b1, 1'b0, 32'd1000,
        REG_BANDWIDTH, 32'h0},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'd1},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_MAX_CREDIT, 32'h00FF_FFFF},
      '{ROW_ITEM, OP_QUERY, 32'd1000,      16'hFFFF, 1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h8000_0000, 16'h8000, 1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'hFFFF_FFFF},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_MAX_CREDIT, 32'h0},
      '{ROW_ITEM, OP_START, 32'h4000_0000, 16'h0000, 1'b1, 1'b0, 32'h4000_0000,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h4000_0000, 16'hFFFF, 1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h4000_0001, 16'h1234, 1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_START, 32'h0000_0000, 16'h0000, 1'b1, 1'b0, 32'h0000_0000,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'hFFFF_FFFF,
        REG_BANDWIDTH, 32'h0},
      '{ROW_ITEM, OP_QUERY, 32'hFFFF_FFFF, 16'h0007, 1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'h0},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_BANDWIDTH, 32'd1000000},
      '{ROW_CSR,  OP_QUERY, 32'h0,         16'h0,    1'b0, 1'b0, 32'h0,
        REG_MAX_CREDIT, 32'd12000}
   };

   credit_based_packet_shaper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_if),
      .rsp_port  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // milliseconds to ticks, kept modulo 2^32
   function automatic logic [TICK_W-1:0] ms_ticks(input logic [63:0] ms);
      logic [63:0] t;
      t = (ms * 64'(TICK_RATE_HZ)) / 64'(MS_PER_S);
      return t[TICK_W-1:0];
   endfunction

   // division by the bandwidth; a zero divisor gives a 32-bit all-ones quotient
   function automatic logic [63:0] per_bandwidth(input logic [63:0] num);
      if (shadow_bandwidth == '0) return 64'h0000_0000_FFFF_FFFF;
      return num / {32'd0, shadow_bandwidth};
   endfunction

   // shaper decision for one item, advancing the shadow activation time
   function automatic decision_type shape_packet(input op_type op,
                                                 input logic [TICK_W-1:0] now,
                                                 input logic [BYTES_W-1:0] bytes);
      decision_type      d;
      logic [TICK_W-1:0] send_ticks;
      logic [TICK_W-1:0] credit_ticks;
      logic [TICK_W-1:0] credit_edge;
      if (op == OP_START) begin
         shadow_activation = now;
         d.ready_res = 1'b0;
      end else if (shadow_activation <= now) begin
         send_ticks   = ms_ticks(per_bandwidth(64'(bytes) * 64'(BYTE_MS)));
         credit_ticks = ms_ticks(per_bandwidth(64'(shadow_max_credit) * 64'(MS_PER_S)));
         credit_edge  = shadow_activation + credit_ticks;
         // idle time beyond the credit bound is lost
         if (credit_edge < now) shadow_activation = now - credit_ticks;
         shadow_activation = shadow_activation + send_ticks;
         d.ready_res = 1'b1;
      end else begin
         d.ready_res = 1'b0;
      end
      d.wakeup_tick = shadow_activation;
      return d;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH at %0t: %s got 0x%08h, expected 0x%08h", $time, what, got, want);
      error_count++;
   endtask

   // one register write, then the enable drops for a cycle
   task automatic write_reg(input csr_reg_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      if (sel == REG_BANDWIDTH) shadow_bandwidth = value;
      else shadow_max_credit = value[CRD_W-1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sender stops and waits for every outstanding decision
   task automatic drain_decisions();
      req_if.valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
   endtask

   // offer one request, at times with a random gap in front of it when not steady
   task automatic send_request(input op_type op, input logic [TICK_W-1:0] now,
                               input logic [BYTES_W-1:0] bytes, input bit typed,
                               input decision_type typed_result);
      decision_type d;
      if (!steady && $urandom_range(0, 99) < 11) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.action       <= op;
      req_if.now_tick     <= now;
      req_if.packet_bytes <= bytes;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      d = shape_packet(op, now, bytes);
      pending_decisions.push_back(typed ? typed_result : d);
   endtask

   // one random phase, with its register setting written first
   task automatic run_phase(input int unsigned phase);
      logic [BPS_W-1:0]   bw;
      logic [CRD_W-1:0]   mc;
      logic [TICK_W-1:0]  now;
      logic [BYTES_W-1:0] bytes;
      int unsigned        span;
      int unsigned        pick;
      case (phase)
         0: begin
            bw = BPS_RESET;
            mc = CRD_RESET;
         end
         1: begin
            bw = 32'd1;
            mc = '1;
         end
         2: begin
            bw = '1;
            mc = '0;
         end
         3: begin
            bw = 32'($urandom_range(1000, 10000000));
            mc = 24'($urandom_range(0, 100000));
         end
         4: begin
            bw = 32'd100000;
            mc = 24'd12000;
         end
         5: begin
            bw = 32'($urandom);
            mc = 24'($urandom);
         end
         6: begin
            bw = 32'd64000;
            mc = 24'($urandom_range(0, 200000));
         end
         default: begin
            bw = BPS_RESET;
            mc = CRD_RESET;
         end
      endcase
      if (bw == '0) bw = 32'd1;
      drain_decisions();
      write_reg(REG_BANDWIDTH, bw);
      write_reg(REG_MAX_CREDIT, 32'(mc));
      // tick step scaled to the delay of a full-size frame
      span = 12000000 / bw;
      if (span < 1) span = 1;
      if (span > 5000) span = 5000;
      now = (phase == 4) ? 32'hFFFF_F000 : 32'($urandom);
      steady = (phase == 3);
      if (phase == PHASE_COUNT - 1) hold_request = 1'b1;
      repeat (PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            // noise: arbitrary tick, possibly behind the running clock
            send_request(op_type'($urandom_range(0, 1)), 32'($urandom), 16'($urandom),
                         1'b0, '0);
         end else if (pick < 15) begin
            send_request(OP_START, now, 16'($urandom), 1'b0, '0);
         end else begin
            if ($urandom_range(0, 3) == 0) now = now + 32'($urandom_range(0, 4 * span));
            else now = now + 32'($urandom_range(0, span));
            pick = $urandom_range(0, 9);
            if (pick < 7) bytes = 16'($urandom_range(40, 1500));
            else if (pick < 9) bytes = 16'($urandom);
            else bytes = '0;
            send_request(OP_QUERY, now, bytes, 1'b0, '0);
         end
      end
      steady = 1'b0;
   endtask

   // response transfers checked in order; receiver stalls driven here too
   initial rsp_if.ready = 1'b0;
   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_decisions.size() == 0) begin
            report_mismatch("response with nothing expected", rsp_if.wakeup_tick, '0);
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_if.ready_res !== want.ready_res)
               report_mismatch("ready_res", 32'(rsp_if.ready_res), 32'(want.ready_res));
            if (rsp_if.wakeup_tick !== want.wakeup_tick)
               report_mismatch("wakeup_tick", rsp_if.wakeup_tick, want.wakeup_tick);
         end
      end
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 11);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row_type row;
      decision_type typed_result;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = REG_BANDWIDTH;
      csr_wdata           = '0;
      req_if.valid        = 1'b0;
      req_if.action       = OP_QUERY;
      req_if.now_tick     = '0;
      req_if.packet_bytes = '0;
      shadow_activation   = '0;
      shadow_bandwidth    = BPS_RESET;
      shadow_max_credit   = CRD_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == ROW_CSR) begin
            drain_decisions();
            write_reg(row.reg_sel, row.reg_value);
         end else begin
            typed_result.ready_res   = row.exp_ready;
            typed_result.wakeup_tick = row.exp_wakeup;
            send_request(row.op, row.now, row.bytes, row.typed, typed_result);
         end
      end

      // random phases
      for (int unsigned p = 0; p < PHASE_COUNT; p++) run_phase(p);

      drain_decisions();
      repeat (100) @(posedge clock);
      if (pending_decisions.size() != 0)
         report_mismatch("decisions never delivered", pending_decisions.size(), '0);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
